[rtl/core/frqg_pkg.sv]
// Shared types, constants and helper functions for the frame-rate quality governor.
// No dependencies; every other file in rtl/core depends on this package.
`default_nettype none

package frqg_pkg;

   localparam int LEVEL_COUNT = 4;
   localparam int LEVEL_W     = 2;
   localparam int ACTION_W    = 2;
   localparam int FRAME_W     = 20;
   localparam int RATE_W      = 24;
   localparam int TIME_W      = 32;
   localparam int CAUSE_W     = 3;

   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;
   localparam int REG_IDX_W   = 3;

   // shared serial divider: 28-bit dividend, 20-bit divisor, one quotient bit per cycle
   localparam int DIV_W       = 28;
   localparam int DIVR_W      = FRAME_W;
   localparam int DIV_CNT_W   = 5;

   localparam logic [RATE_W-1:0] RATE_MAX    = 24'hFFFFFF;
   localparam logic [DIV_W-1:0]  RATE_SCALE  = 28'd256000000;
   localparam logic [DIVR_W-1:0] AVG_DIVISOR = 20'd10;
   localparam logic [DIV_W-1:0]  AVG_ROUND   = 28'd5;

   localparam logic [RATE_W-1:0]  DOWN_RATE_RST   = 24'd6912;
   localparam logic [RATE_W-1:0]  STRONG_RATE_RST = 24'd6144;
   localparam logic [RATE_W-1:0]  UP_RATE_RST     = 24'd8960;
   localparam logic [TIME_W-1:0]  SUSTAIN_RST     = 32'd3000000;
   localparam logic               AUTO_RST        = 1'b1;
   localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 2'd2;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL_RST   = 2'd2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_SET   = 2'd1,
      ACT_CYCLE = 2'd2
   } action_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NONE   = 3'd0,
      CAUSE_STRONG = 3'd1,
      CAUSE_DOWN   = 3'd2,
      CAUSE_UP     = 3'd3,
      CAUSE_MANUAL = 3'd4
   } cause_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DOWN_RATE   = 3'd0,
      REG_STRONG_RATE = 3'd1,
      REG_UP_RATE     = 3'd2,
      REG_SUSTAIN     = 3'd3,
      REG_AUTO        = 3'd4,
      REG_START_LEVEL = 3'd5,
      REG_TOP_LEVEL   = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [RATE_W-1:0]  down_rate;
      logic [RATE_W-1:0]  strong_down_rate;
      logic [RATE_W-1:0]  up_rate;
      logic [TIME_W-1:0]  sustain_us;
      logic               auto_enable;
      logic [LEVEL_W-1:0] start_level;
      logic [LEVEL_W-1:0] top_level;
   } cfg_type;

   // saturate a level code to the last legal level
   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      if ({1'b0, v} >= (LEVEL_W+1)'(LEVEL_COUNT)) begin
         r = LEVEL_W'(LEVEL_COUNT - 1);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // next level, wrapping to zero
   function automatic logic [LEVEL_W-1:0] wrap_level(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      if (v == LEVEL_W'(LEVEL_COUNT - 1)) begin
         r = '0;
      end else begin
         r = v + LEVEL_W'(1);
      end
      return r;
   endfunction

   // saturating duration add
   function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W:0]   b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + b;
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/frqg_if.sv]
// Valid/ready channel interfaces for tick/command words and result words.
// Depends on frqg_pkg for field widths.
`default_nettype none

interface frqg_req_if;
   logic                            valid;
   logic                            ready;
   logic [frqg_pkg::ACTION_W-1:0]   action;
   logic [frqg_pkg::FRAME_W-1:0]    frame_us;
   logic [frqg_pkg::LEVEL_W-1:0]    new_level;

   modport source (output valid, action, frame_us, new_level, input ready);
   modport sink   (input valid, action, frame_us, new_level, output ready);
endinterface

interface frqg_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [frqg_pkg::LEVEL_W-1:0]    level;
   logic [frqg_pkg::LEVEL_W-1:0]    prior_level;
   logic                            changed;
   logic [frqg_pkg::CAUSE_W-1:0]    cause;
   logic [frqg_pkg::RATE_W-1:0]     smoothed_rate;
   logic [frqg_pkg::TIME_W-1:0]     since_change_us;

   modport source (output valid, level, prior_level, changed, cause, smoothed_rate,
                   since_change_us, input ready);
   modport sink   (input valid, level, prior_level, changed, cause, smoothed_rate,
                   since_change_us, output ready);
endinterface

`default_nettype wire

[rtl/core/frame_rate_quality_governor.sv]
// Frame-rate quality governor: one result word per accepted tick/command word.
// Tick with nonzero frame time: two passes through the
// bit-serial divider (instantaneous rate, then the divide-by-ten of the blend).
// Tick with zero frame time skips the divider; manual set/cycle and unused action skip it too.
// Input is taken again while a finished result word still waits on rsp_ch.
// Synchronous active-high reset: level = start level default, rate/durations zero.
`default_nettype none

module frame_rate_quality_governor (
   input  logic                         clock,
   input  logic                         reset,
   frqg_req_if.sink                     req_ch,
   frqg_rsp_if.source                   rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [frqg_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [frqg_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [frqg_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import frqg_pkg::*;

   // Sequencer: one word at a time walks through these steps.
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SINCE    = 9'b000000010,
      S_DIV_INST = 9'b000000100,
      S_DIV_AVG  = 9'b000001000,
      S_CLASS    = 9'b000010000,
      S_DOWN     = 9'b000100000,
      S_UP       = 9'b001000000,
      S_MAN      = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   cfg_type cfg;

   state_type            state_ff, state_in;

   // captured word
   logic [ACTION_W-1:0]  action_ff, action_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [LEVEL_W-1:0]   new_level_ff, new_level_in;

   // governor state
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LEVEL_W-1:0]   prior_ff, prior_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [TIME_W-1:0]    low_ff, low_in;
   logic [TIME_W-1:0]    high_ff, high_in;
   logic [TIME_W-1:0]    since_ff, since_in;

   // per-word scratch
   logic [TIME_W:0]      up_need_ff, up_need_in;
   logic                 strong_ff, strong_in;
   logic                 changed_ff, changed_in;
   logic [CAUSE_W-1:0]   cause_ff, cause_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;
   logic [LEVEL_W-1:0]   rsp_prior_ff, rsp_prior_in;
   logic                 rsp_changed_ff, rsp_changed_in;
   logic [CAUSE_W-1:0]   rsp_cause_ff, rsp_cause_in;
   logic [RATE_W-1:0]    rsp_rate_ff, rsp_rate_in;
   logic [TIME_W-1:0]    rsp_since_ff, rsp_since_in;

   // divider hookup
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVR_W-1:0]    div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     div_q;

   logic                 accept;
   logic                 rsp_free;
   logic [RATE_W-1:0]    q_sat;
   logic [DIV_W-1:0]     blend;
   logic [LEVEL_W-1:0]   top;
   logic [LEVEL_W-1:0]   target;

   frqg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   frqg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;
   assign rsp_free     = ~rsp_valid_ff | rsp_ch.ready;

   // Saturate a divider quotient to the 24-bit rate range.
   assign q_sat = (|div_q[DIV_W-1:RATE_W]) ? RATE_MAX : div_q[RATE_W-1:0];

   // Blend numerator: 9*avg + inst + 5, inst taken from the first divide.
   assign blend = ({{(DIV_W-RATE_W){1'b0}}, rate_ff} << 3)
                + {{(DIV_W-RATE_W){1'b0}}, rate_ff}
                + {{(DIV_W-RATE_W){1'b0}}, q_sat}
                + AVG_ROUND;

   assign top    = clamp_level(cfg.top_level);
   assign target = (action_ff == ACT_SET) ? clamp_level(new_level_ff) : wrap_level(level_ff);

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      frame_in     = frame_ff;
      new_level_in = new_level_ff;
      level_in     = level_ff;
      prior_in     = prior_ff;
      rate_in      = rate_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      since_in     = since_ff;
      up_need_in   = up_need_ff;
      strong_in    = strong_ff;
      changed_in   = changed_ff;
      cause_in     = cause_ff;
      div_start    = 1'b0;
      div_dividend = RATE_SCALE;
      div_divisor  = frame_ff;

      rsp_valid_in   = rsp_valid_ff & ~rsp_ch.ready;
      rsp_level_in   = rsp_level_ff;
      rsp_prior_in   = rsp_prior_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_cause_in   = rsp_cause_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_since_in   = rsp_since_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in    = req_ch.action;
               frame_in     = req_ch.frame_us;
               new_level_in = req_ch.new_level;
               changed_in   = 1'b0;
               cause_in     = CAUSE_NONE;
               if (req_ch.action == ACT_TICK) begin
                  state_in = S_SINCE;
               end else if (req_ch.action == ACT_SET || req_ch.action == ACT_CYCLE) begin
                  state_in = S_MAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SINCE: begin
            // advance the since-change clock; latch the upgrade hold time (1.5x sustain)
            since_in   = sat_time(since_ff, {{(TIME_W+1-FRAME_W){1'b0}}, frame_ff});
            up_need_in = {1'b0, cfg.sustain_us}
                       + {2'b0, cfg.sustain_us[TIME_W-1:1]}
                       + {{TIME_W{1'b0}}, cfg.sustain_us[0]};
            if (frame_ff != '0) begin
               div_start = 1'b1;
               state_in  = S_DIV_INST;
            end else begin
               state_in  = S_CLASS;
            end
         end
         S_DIV_INST: begin
            // instantaneous rate ready: launch the rounded divide by ten
            if (div_done) begin
               div_start    = 1'b1;
               div_dividend = blend;
               div_divisor  = AVG_DIVISOR;
               state_in     = S_DIV_AVG;
            end
         end
         S_DIV_AVG: begin
            if (div_done) begin
               rate_in  = q_sat;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            strong_in = (rate_ff < cfg.strong_down_rate);
            if (!cfg.auto_enable) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DOWN;
               if (rate_ff < cfg.strong_down_rate) begin
                  // well below target: count low time double
                  low_in  = sat_time(low_ff, {{(TIME_W-FRAME_W){1'b0}}, frame_ff, 1'b0});
                  high_in = '0;
               end else if (rate_ff < cfg.down_rate) begin
                  low_in  = sat_time(low_ff, {{(TIME_W+1-FRAME_W){1'b0}}, frame_ff});
                  high_in = '0;
               end else if (rate_ff >= cfg.up_rate) begin
                  high_in = sat_time(high_ff, {{(TIME_W+1-FRAME_W){1'b0}}, frame_ff});
                  low_in  = '0;
               end else begin
                  low_in  = '0;
                  high_in = '0;
               end
            end
         end
         S_DOWN: begin
            state_in = S_UP;
            if (low_ff >= cfg.sustain_us && level_ff != '0) begin
               prior_in   = level_ff;
               level_in   = level_ff - LEVEL_W'(1);
               since_in   = '0;
               changed_in = 1'b1;
               cause_in   = strong_ff ? CAUSE_STRONG : CAUSE_DOWN;
               low_in     = '0;
            end
         end
         S_UP: begin
            // checked after the downgrade, so a zero sustain can bounce back up
            state_in = S_DONE;
            if ({1'b0, high_ff} >= up_need_ff && level_ff < top) begin
               prior_in   = level_ff;
               level_in   = level_ff + LEVEL_W'(1);
               since_in   = '0;
               changed_in = 1'b1;
               cause_in   = CAUSE_UP;
               high_in    = '0;
            end
         end
         S_MAN: begin
            // manual set or cycle: record only a real change, always drop durations
            state_in = S_DONE;
            if (target != level_ff) begin
               prior_in   = level_ff;
               level_in   = target;
               since_in   = '0;
               changed_in = 1'b1;
               cause_in   = CAUSE_MANUAL;
            end
            low_in  = '0;
            high_in = '0;
         end
         S_DONE: begin
            // hold until the result register frees up, then load it
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = level_ff;
               rsp_prior_in   = prior_ff;
               rsp_changed_in = changed_ff;
               rsp_cause_in   = cause_ff;
               rsp_rate_in    = rate_ff;
               rsp_since_in   = since_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= clamp_level(START_LEVEL_RST);
         prior_ff     <= clamp_level(START_LEVEL_RST);
         rate_ff      <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         prior_ff     <= prior_in;
         rate_ff      <= rate_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      frame_ff       <= frame_in;
      new_level_ff   <= new_level_in;
      up_need_ff     <= up_need_in;
      strong_ff      <= strong_in;
      changed_ff     <= changed_in;
      cause_ff       <= cause_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_prior_ff   <= rsp_prior_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_cause_ff   <= rsp_cause_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_since_ff   <= rsp_since_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.level           = rsp_level_ff;
   assign rsp_ch.prior_level     = rsp_prior_ff;
   assign rsp_ch.changed         = rsp_changed_ff;
   assign rsp_ch.cause           = rsp_cause_ff;
   assign rsp_ch.smoothed_rate   = rsp_rate_ff;
   assign rsp_ch.since_change_us = rsp_since_ff;

endmodule

`default_nettype wire

[rtl/core/frqg_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on frqg_pkg for operand widths.
`default_nettype none

module frqg_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [frqg_pkg::DIV_W-1:0]   dividend,
   input  logic [frqg_pkg::DIVR_W-1:0]  divisor,
   output logic                         done,
   output logic [frqg_pkg::DIV_W-1:0]   quotient
);
   import frqg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVR_W-1:0]    dsr_ff, dsr_in;

   logic [DIVR_W:0]      rem_sh;
   logic [DIVR_W:0]      diff;
   logic                 fits;

   // shift in the next dividend bit, trial subtract
   assign rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign fits   = ~diff[DIVR_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

[rtl/core/frqg_csr.sv]
// APB-style configuration register file for the governor thresholds and levels.
// Depends on frqg_pkg for the register map and the cfg_type struct.
`default_nettype none

module frqg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [frqg_pkg::CSR_AW-1:0]  paddr,
   input  logic [frqg_pkg::CSR_DW-1:0]  pwdata,
   output logic [frqg_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready,
   output frqg_pkg::cfg_type            cfg
);
   import frqg_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] idx;
   logic             wr_en;

   assign idx    = paddr[CSR_AW-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_DOWN_RATE:   cfg_in.down_rate        = pwdata[RATE_W-1:0];
            REG_STRONG_RATE: cfg_in.strong_down_rate = pwdata[RATE_W-1:0];
            REG_UP_RATE:     cfg_in.up_rate          = pwdata[RATE_W-1:0];
            REG_SUSTAIN:     cfg_in.sustain_us       = pwdata[TIME_W-1:0];
            REG_AUTO:        cfg_in.auto_enable      = pwdata[0];
            REG_START_LEVEL: cfg_in.start_level      = pwdata[LEVEL_W-1:0];
            REG_TOP_LEVEL:   cfg_in.top_level        = pwdata[LEVEL_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DOWN_RATE:   prdata = CSR_DW'(cfg_ff.down_rate);
         REG_STRONG_RATE: prdata = CSR_DW'(cfg_ff.strong_down_rate);
         REG_UP_RATE:     prdata = CSR_DW'(cfg_ff.up_rate);
         REG_SUSTAIN:     prdata = CSR_DW'(cfg_ff.sustain_us);
         REG_AUTO:        prdata = CSR_DW'(cfg_ff.auto_enable);
         REG_START_LEVEL: prdata = CSR_DW'(cfg_ff.start_level);
         REG_TOP_LEVEL:   prdata = CSR_DW'(cfg_ff.top_level);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.down_rate        <= DOWN_RATE_RST;
         cfg_ff.strong_down_rate <= STRONG_RATE_RST;
         cfg_ff.up_rate          <= UP_RATE_RST;
         cfg_ff.sustain_us       <= SUSTAIN_RST;
         cfg_ff.auto_enable      <= AUTO_RST;
         cfg_ff.start_level      <= START_LEVEL_RST;
         cfg_ff.top_level        <= TOP_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire
